### rtl/core/frapq_pkg.sv
// Shared constants, codes and hand-off structs for the Fenwick range-add /
// point-query block. No dependencies.
package frapq_pkg;

    localparam int MAX_ENTRIES = 1024;
    localparam int IDX_W       = 11;
    localparam int CELL_AW     = $clog2(MAX_ENTRIES);
    localparam int DATA_W      = 32;
    localparam int ACT_W       = 2;
    localparam int ADDR_W      = 3;

    // Configuration register indexes (byte address is 4 * index)
    localparam logic REG_SIZE_IN_USE = 1'b0;

    localparam logic [IDX_W-1:0] SIZE_RESET = IDX_W'(MAX_ENTRIES);

    typedef logic [IDX_W-1:0] index_t;

    typedef enum logic [ACT_W-1:0] {
        ACT_PREFIX_ADD  = 2'd0,
        ACT_RANGE_ADD   = 2'd1,
        ACT_POINT_QUERY = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        W_CLEAR,
        W_IDLE,
        W_LOAD,
        W_STEP,
        W_DONE
    } walk_state_t;

    typedef struct packed {
        action_t                   action;
        index_t                    first_index;
        index_t                    last_index;
        logic signed [DATA_W-1:0]  amount;
        index_t                    limit;
    } walk_cmd_t;

    typedef struct packed {
        logic signed [DATA_W-1:0]  entry_value;
        logic                      status;
    } walk_res_t;

endpackage

### rtl/core/frapq_walker.sv
// Tree walker: cell memory, clearing pass and the sequencer that runs the
// read-modify-write walks over one shared adder. Depends on frapq_pkg.
module frapq_walker
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    input  frapq_pkg::walk_cmd_t cmd,
    output logic                 cmd_ready,
    output logic                 res_valid,
    output frapq_pkg::walk_res_t res,
    input  logic                 res_ready
);
    import frapq_pkg::*;

    function automatic logic [CELL_AW-1:0] cell_addr(input index_t x);
        index_t t;
        t = x - IDX_W'(1);
        return t[CELL_AW-1:0];
    endfunction

    walk_state_t         state_reg, state_next;
    logic [CELL_AW-1:0]  clr_reg, clr_next;
    logic                second_reg, second_next;
    logic                query_reg, query_next;
    logic                status_reg, status_next;
    index_t              idx_reg, idx_next;
    index_t              hi_reg, hi_next;
    index_t              lim_reg, lim_next;
    logic [DATA_W-1:0]   amt_reg, amt_next;
    logic [DATA_W-1:0]   acc_reg, acc_next;

    logic [DATA_W-1:0]   cell_mem [MAX_ENTRIES];
    logic [DATA_W-1:0]   rd_q_reg;
    logic                rd_en, wr_en;
    logic [CELL_AW-1:0]  rd_addr, wr_addr;
    logic [DATA_W-1:0]   wr_data;

    index_t              low_bit;
    logic [IDX_W:0]      up_nxt;
    index_t              dn_nxt;
    logic [DATA_W-1:0]   sum;
    logic                a_ok, b_ok, a_lt_b;
    index_t              lo_idx, hi_idx, lo_m1;

    // One adder serves both walks: accumulate for a query, bump a cell for an add
    assign low_bit = idx_reg & (~idx_reg + IDX_W'(1));
    assign up_nxt  = {1'b0, idx_reg} + {1'b0, low_bit};
    assign dn_nxt  = idx_reg - low_bit;
    assign sum     = rd_q_reg + (query_reg ? acc_reg : amt_reg);

    assign a_ok   = (cmd.first_index != '0) && (cmd.first_index <= cmd.limit);
    assign b_ok   = (cmd.last_index != '0) && (cmd.last_index <= cmd.limit);
    assign a_lt_b = cmd.first_index < cmd.last_index;
    assign lo_idx = a_lt_b ? cmd.first_index : cmd.last_index;
    assign hi_idx = a_lt_b ? cmd.last_index : cmd.first_index;
    assign lo_m1  = lo_idx - IDX_W'(1);

    assign res.entry_value = acc_reg;
    assign res.status      = status_reg;

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        second_next = second_reg;
        query_next  = query_reg;
        status_next = status_reg;
        idx_next    = idx_reg;
        hi_next     = hi_reg;
        lim_next    = lim_reg;
        amt_next    = amt_reg;
        acc_next    = acc_reg;
        rd_en       = 1'b0;
        rd_addr     = '0;
        wr_en       = 1'b0;
        wr_addr     = '0;
        wr_data     = '0;
        cmd_ready   = 1'b0;
        res_valid   = 1'b0;

        case (state_reg)
            W_CLEAR:
            begin
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                clr_next = clr_reg + CELL_AW'(1);
                if (clr_reg == CELL_AW'(MAX_ENTRIES - 1))
                begin
                    state_next = W_IDLE;
                end
            end

            W_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    lim_next    = cmd.limit;
                    acc_next    = '0;
                    status_next = 1'b0;
                    second_next = 1'b0;
                    query_next  = 1'b0;
                    state_next  = W_LOAD;
                    case (cmd.action)
                        ACT_PREFIX_ADD:
                        begin
                            idx_next = cmd.first_index;
                            amt_next = cmd.amount;
                            if (!a_ok)
                            begin
                                status_next = 1'b1;
                                state_next  = W_DONE;
                            end
                        end
                        ACT_RANGE_ADD:
                        begin
                            hi_next = hi_idx;
                            if (!(a_ok && b_ok))
                            begin
                                status_next = 1'b1;
                                state_next  = W_DONE;
                            end
                            else if (lo_m1 != '0)
                            begin
                                // take back the amount below the range first
                                idx_next    = lo_m1;
                                amt_next    = DATA_W'(0) - cmd.amount;
                                second_next = 1'b1;
                            end
                            else
                            begin
                                idx_next = hi_idx;
                                amt_next = cmd.amount;
                            end
                        end
                        ACT_POINT_QUERY:
                        begin
                            idx_next   = cmd.first_index;
                            query_next = 1'b1;
                            if (!a_ok)
                            begin
                                query_next  = 1'b0;
                                status_next = 1'b1;
                                state_next  = W_DONE;
                            end
                        end
                        default:
                        begin
                            status_next = 1'b1;
                            state_next  = W_DONE;
                        end
                    endcase
                end
            end

            W_LOAD:
            begin
                rd_en      = 1'b1;
                rd_addr    = cell_addr(idx_reg);
                state_next = W_STEP;
            end

            W_STEP:
            begin
                if (query_reg)
                begin
                    acc_next = sum;
                    if (up_nxt > {1'b0, lim_reg})
                    begin
                        state_next = W_DONE;
                    end
                    else
                    begin
                        idx_next = up_nxt[IDX_W-1:0];
                        rd_en    = 1'b1;
                        rd_addr  = cell_addr(up_nxt[IDX_W-1:0]);
                    end
                end
                else
                begin
                    // write this cell while the next one down is read
                    wr_en   = 1'b1;
                    wr_addr = cell_addr(idx_reg);
                    wr_data = sum;
                    if (dn_nxt == '0)
                    begin
                        if (second_reg)
                        begin
                            second_next = 1'b0;
                            idx_next    = hi_reg;
                            amt_next    = DATA_W'(0) - amt_reg;
                            state_next  = W_LOAD;
                        end
                        else
                        begin
                            state_next = W_DONE;
                        end
                    end
                    else
                    begin
                        idx_next = dn_nxt;
                        rd_en    = 1'b1;
                        rd_addr  = cell_addr(dn_nxt);
                    end
                end
            end

            W_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = W_IDLE;
                end
            end

            default:
            begin
                state_next = W_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= W_CLEAR;
            clr_reg    <= '0;
            second_reg <= 1'b0;
            query_reg  <= 1'b0;
            status_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            second_reg <= second_next;
            query_reg  <= query_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        hi_reg  <= hi_next;
        lim_reg <= lim_next;
        amt_reg <= amt_next;
        acc_reg <= acc_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            cell_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_q_reg <= cell_mem[rd_addr];
        end
    end

endmodule

### rtl/core/fenwick_range_add_point_query.sv
// Top level of the Fenwick range-add / point-query block: stream ports,
// configuration register, output register. Depends on frapq_pkg, frapq_walker.
//
// Keeps a binary indexed tree of 1024 cells of 32 bits and takes one word at
// a time: a prefix add (amount onto entries 1..first_index), a range add
// (amount onto the entries between first_index and last_index, either order)
// or a point query (value of entry first_index). Every word gives exactly one
// result word: entry_value (zero for adds and errors) and status (1 when an
// index lies outside 1..size_in_use or the action code is unused; nothing is
// changed). Sums wrap at 32 bits. After reset a clearing pass zeroes all 1024
// cells, and s_axis_tready stays low until it ends. The walker works on one
// word at a time, one tree step per cycle through a single cell-memory read
// port and one shared adder: a prefix add or a query runs one walk; a range
// add whose lower index is above 1 runs two walks back to back; a rejected
// word runs no walk. The result sits in an output register, so the next word
// is taken while the result waits. size_in_use lies at byte address 0;
// writing it leaves the cells untouched, and only its low 11 bits are kept,
// so values from 1025 to 2047 act as 1024.
module fenwick_range_add_point_query
(
    input  logic                           clk,
    input  logic                           rst_n,
    // slave side
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [55:0]                    s_axis_tdata,  // first_index, last_index, amount, pad
    input  logic [frapq_pkg::ACT_W-1:0]    s_axis_tuser,  // action
    // master side
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [frapq_pkg::DATA_W-1:0]   m_axis_tdata,  // entry_value
    output logic                           m_axis_tuser,  // status
    // configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [frapq_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import frapq_pkg::*;

    index_t             size_reg, size_next;
    index_t             limit;
    logic               cfg_wr;

    walk_cmd_t          cmd;
    logic               cmd_ready;
    logic               res_valid;
    logic               res_ready;
    walk_res_t          res;

    logic               out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]  out_data_reg, out_data_next;
    logic               out_status_reg, out_status_next;

    // Register port: no wait states; only index 0 is backed by storage
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_SIZE_IN_USE) ? {{(32 - IDX_W){1'b0}}, size_reg} : '0;

    always_comb
    begin
        size_next = size_reg;
        if (cfg_wr && (paddr[2] == REG_SIZE_IN_USE))
        begin
            size_next = pwdata[IDX_W-1:0];
        end
    end

    // Clamp the size to the tree capacity; zero leaves every index invalid
    assign limit = (size_reg > IDX_W'(MAX_ENTRIES)) ? IDX_W'(MAX_ENTRIES) : size_reg;

    // Unpack the input word for the walker
    assign cmd.action      = action_t'(s_axis_tuser);
    assign cmd.first_index = s_axis_tdata[10:0];
    assign cmd.last_index  = s_axis_tdata[21:11];
    assign cmd.amount      = s_axis_tdata[53:22];
    assign cmd.limit       = limit;
    assign s_axis_tready   = cmd_ready;

    frapq_walker u_walker
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (s_axis_tvalid),
        .cmd       (cmd),
        .cmd_ready (cmd_ready),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready)
    );

    // Output register: load a finished result when empty or being drained
    assign res_ready = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        out_status_next = out_status_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next  = 1'b1;
            out_data_next   = res.entry_value;
            out_status_next = res.status;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg      <= SIZE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            size_reg      <= size_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg   <= out_data_next;
        out_status_reg <= out_status_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_status_reg;

    // One word at a time: the walker drops ready as soon as it takes a word
    a_one_word_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("walker took a second word while busy");

    // A rejected word never carries a value
    a_error_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("error result with non-zero entry_value");

    // A result handed over by the walker must show up on the master side
    a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_ready) |=> m_axis_tvalid)
        else $error("result lost between walker and output register");

endmodule
